>>> hdl/uart_ring_buffer_path_unit_defines.svh
// Assertion macros for the checker file of the UART ring buffer path.
`ifndef UART_RING_BUFFER_PATH_UNIT_DEFINES_SVH
`define UART_RING_BUFFER_PATH_UNIT_DEFINES_SVH

// Same-cycle implication under the active-low asynchronous reset.
`define URBP_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication under the active-low asynchronous reset.
`define URBP_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/urbp_pkg.sv
// ----------------------------------------------------------------------------
// urbp_pkg
// Types and constants of the UART ring buffer path: ring sizes, action codes,
// status marks and the word formats of the command and result channels.
// ----------------------------------------------------------------------------
package urbp_pkg;

  localparam int unsigned TX_DEPTH = 256;
  localparam int unsigned RX_DEPTH = 256;
  localparam int unsigned TX_AW    = (TX_DEPTH > 1) ? $clog2(TX_DEPTH) : 1;
  localparam int unsigned RX_AW    = (RX_DEPTH > 1) ? $clog2(RX_DEPTH) : 1;

  localparam logic [1:0] ACT_QUEUE    = 2'd0;
  localparam logic [1:0] ACT_TX_EMPTY = 2'd1;
  localparam logic [1:0] ACT_RX_BYTE  = 2'd2;
  localparam logic [1:0] ACT_SW_READ  = 2'd3;

  localparam logic [7:0] MARK_EMPTY = 8'h45;  // 'E'
  localparam logic [7:0] MARK_FULL  = 8'h46;  // 'F'

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] data_byte;
  } in_t;

  typedef struct packed {
    logic       line_send;
    logic [7:0] line_byte;
    logic [7:0] read_byte;
    logic       tx_irq_enabled;
    logic [7:0] tx_fill;
    logic [7:0] rx_fill;
  } out_t;

endpackage

>>> hdl/uart_ring_buffer_path_unit.sv
// ----------------------------------------------------------------------------
// uart_ring_buffer_path_unit
// Buffered UART data path: a transmit ring and a receive ring, each held in a
// single-port synchronous memory, with masked wrapping indices.
//
//   Channel   Handshake               Word
//   command   start high, busy low    in_i  (action, data_byte)
//   result    res_valid_o, 1 cycle    res_o (line and fill status)
//
// One command word is taken per clock; its result word is shown for one
// cycle, the cycle after acceptance, when the registered read of the
// ring memory returns. busy stays low, since each word makes at most one
// memory access and a word written is readable by the next one. Reset
// clears the indices and the interrupt enable; ring contents are unset
// until written. The receiver cannot stall the result channel.
// ----------------------------------------------------------------------------
module uart_ring_buffer_path_unit (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  input  urbp_pkg::in_t  in_i,
  output logic           res_valid_o,
  output urbp_pkg::out_t res_o
);
  import urbp_pkg::*;

  logic             tx_en, tx_we, rx_en, rx_we;
  logic [TX_AW-1:0] tx_addr;
  logic [RX_AW-1:0] rx_addr;
  logic [7:0]       tx_wdata, tx_rdata, rx_wdata, rx_rdata;

  urbp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .in_i        (in_i),
    .res_valid_o (res_valid_o),
    .res_o       (res_o),
    .tx_en_o     (tx_en),
    .tx_we_o     (tx_we),
    .tx_addr_o   (tx_addr),
    .tx_wdata_o  (tx_wdata),
    .tx_rdata_i  (tx_rdata),
    .rx_en_o     (rx_en),
    .rx_we_o     (rx_we),
    .rx_addr_o   (rx_addr),
    .rx_wdata_o  (rx_wdata),
    .rx_rdata_i  (rx_rdata)
  );

  urbp_ram #(.DEPTH(TX_DEPTH), .WIDTH(8), .AW(TX_AW)) u_tx_ram (
    .clk_i   (clk_i),
    .en_i    (tx_en),
    .we_i    (tx_we),
    .addr_i  (tx_addr),
    .wdata_i (tx_wdata),
    .rdata_o (tx_rdata)
  );

  urbp_ram #(.DEPTH(RX_DEPTH), .WIDTH(8), .AW(RX_AW)) u_rx_ram (
    .clk_i   (clk_i),
    .en_i    (rx_en),
    .we_i    (rx_we),
    .addr_i  (rx_addr),
    .wdata_i (rx_wdata),
    .rdata_o (rx_rdata)
  );

endmodule

>>> hdl/urbp_ram.sv
// ----------------------------------------------------------------------------
// urbp_ram
// Single-port synchronous byte store: one write or one read per cycle, read
// data registered.
// ----------------------------------------------------------------------------
module urbp_ram #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned WIDTH = 8,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic             we_i,
  input  logic [AW-1:0]    addr_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> hdl/urbp_ctrl.sv
// ----------------------------------------------------------------------------
// urbp_ctrl
// Ring indices, interrupt enable and result assembly. Decodes each command
// word into at most one ring access, shapes the result word the cycle after.
// ----------------------------------------------------------------------------
module urbp_ctrl (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start,
  output logic                      busy,
  input  urbp_pkg::in_t             in_i,
  output logic                      res_valid_o,
  output urbp_pkg::out_t            res_o,
  output logic                      tx_en_o,
  output logic                      tx_we_o,
  output logic [urbp_pkg::TX_AW-1:0] tx_addr_o,
  output logic [7:0]                tx_wdata_o,
  input  logic [7:0]                tx_rdata_i,
  output logic                      rx_en_o,
  output logic                      rx_we_o,
  output logic [urbp_pkg::RX_AW-1:0] rx_addr_o,
  output logic [7:0]                rx_wdata_o,
  input  logic [7:0]                rx_rdata_i
);
  import urbp_pkg::*;

  localparam logic [RX_AW-1:0] RX_ALMOST = RX_AW'(RX_DEPTH - 1);

  logic [TX_AW-1:0] tx_wr_q, tx_wr_d, tx_rd_q, tx_rd_d;
  logic [RX_AW-1:0] rx_wr_q, rx_wr_d, rx_rd_q, rx_rd_d;
  logic             irq_q, irq_d;
  logic             valid_q, pop_tx_q, pop_tx_d, pop_rx_q, pop_rx_d;
  logic             mark_q, mark_d;
  logic [7:0]       mark_byte_q, mark_byte_d;
  logic [RX_AW-1:0] rx_cnt_next;
  logic [TX_AW-1:0] tx_cnt, tx_cnt_pop;
  logic [RX_AW-1:0] rx_cnt;
  logic             accept;

  // Every command makes at most one ring access, so a new word is taken each cycle.
  assign busy   = 1'b0;
  assign accept = start && !busy;

  assign rx_cnt_next = rx_wr_q + RX_AW'(1) - rx_rd_q;
  assign tx_cnt_pop  = tx_wr_q - tx_rd_q - TX_AW'(1);

  always_comb begin
    tx_wr_d     = tx_wr_q;
    tx_rd_d     = tx_rd_q;
    rx_wr_d     = rx_wr_q;
    rx_rd_d     = rx_rd_q;
    irq_d       = irq_q;
    pop_tx_d    = 1'b0;
    pop_rx_d    = 1'b0;
    mark_d      = 1'b0;
    mark_byte_d = 8'h00;
    tx_en_o     = 1'b0;
    tx_we_o     = 1'b0;
    tx_addr_o   = tx_wr_q;
    tx_wdata_o  = in_i.data_byte;
    rx_en_o     = 1'b0;
    rx_we_o     = 1'b0;
    rx_addr_o   = rx_wr_q;
    rx_wdata_o  = in_i.data_byte;
    if (accept) begin
      case (in_i.action)
        ACT_QUEUE: begin
          tx_en_o = 1'b1;
          tx_we_o = 1'b1;
          tx_wr_d = tx_wr_q + TX_AW'(1);
          irq_d   = 1'b1;
        end
        ACT_TX_EMPTY: begin
          if (irq_q) begin
            tx_en_o   = 1'b1;
            tx_addr_o = tx_rd_q;
            tx_rd_d   = tx_rd_q + TX_AW'(1);
            pop_tx_d  = 1'b1;
            if (tx_cnt_pop == '0) begin
              irq_d = 1'b0;
            end
          end
        end
        ACT_RX_BYTE: begin
          rx_en_o = 1'b1;
          rx_we_o = 1'b1;
          rx_wr_d = rx_wr_q + RX_AW'(1);
          if (rx_cnt_next == '0) begin
            mark_d      = 1'b1;
            mark_byte_d = MARK_EMPTY;
          end else if (rx_cnt_next == RX_ALMOST) begin
            mark_d      = 1'b1;
            mark_byte_d = MARK_FULL;
          end
        end
        default: begin
          rx_en_o   = 1'b1;
          rx_addr_o = rx_rd_q;
          rx_rd_d   = rx_rd_q + RX_AW'(1);
          pop_rx_d  = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tx_wr_q  <= '0;
      tx_rd_q  <= '0;
      rx_wr_q  <= '0;
      rx_rd_q  <= '0;
      irq_q    <= 1'b0;
      valid_q  <= 1'b0;
      pop_tx_q <= 1'b0;
      pop_rx_q <= 1'b0;
      mark_q   <= 1'b0;
    end else begin
      tx_wr_q  <= tx_wr_d;
      tx_rd_q  <= tx_rd_d;
      rx_wr_q  <= rx_wr_d;
      rx_rd_q  <= rx_rd_d;
      irq_q    <= irq_d;
      valid_q  <= accept;
      pop_tx_q <= pop_tx_d;
      pop_rx_q <= pop_rx_d;
      mark_q   <= mark_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mark_byte_q <= mark_byte_d;
  end

  // Indices already hold the values left by the word being reported.
  assign tx_cnt = tx_wr_q - tx_rd_q;
  assign rx_cnt = rx_wr_q - rx_rd_q;

  always_comb begin
    res_o.line_send      = pop_tx_q || mark_q;
    res_o.line_byte      = pop_tx_q ? tx_rdata_i : (mark_q ? mark_byte_q : 8'h00);
    res_o.read_byte      = pop_rx_q ? rx_rdata_i : 8'h00;
    res_o.tx_irq_enabled = irq_q;
    res_o.tx_fill        = 8'(tx_cnt);
    res_o.rx_fill        = 8'(rx_cnt);
  end

  assign res_valid_o = valid_q;

endmodule

>>> hdl/urbp_checker.sv
// ----------------------------------------------------------------------------
// urbp_checker
// Port-level checks of the UART ring buffer path, bound to the top level.
// ----------------------------------------------------------------------------
`include "uart_ring_buffer_path_unit_defines.svh"

module urbp_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           start,
  input logic           busy,
  input urbp_pkg::in_t  in_i,
  input logic           res_valid_o,
  input urbp_pkg::out_t res_o
);
  import urbp_pkg::*;

  // Every accepted word gives exactly one result word on the next cycle.
  `URBP_ASSERT_NXT(a_one_result, clk_i, rst_ni, start && !busy, res_valid_o, "result word missing")
  `URBP_ASSERT_NXT(a_no_extra, clk_i, rst_ni, !(start && !busy), !res_valid_o, "unrequested result word")

  // The interrupt is only ever off with an empty transmit ring.
  `URBP_ASSERT_IMP(a_irq_off_empty, clk_i, rst_ni, res_valid_o && !res_o.tx_irq_enabled, res_o.tx_fill == 8'h00, "interrupt off with data queued")

  // A nonzero read byte can only come from a software read.
  `URBP_ASSERT_IMP(a_read_src, clk_i, rst_ni, res_valid_o && (res_o.read_byte != 8'h00), $past(in_i.action) == ACT_SW_READ, "read byte without software read")

endmodule

bind uart_ring_buffer_path_unit urbp_checker u_urbp_checker (.*);
